// File: src/hcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the Hall commutation and speed block.
// ----------------------------------------------------------------------------
package hcs_pkg;

  // Field widths fixed by the interface
  localparam int TIMER_IN_W = 16;
  localparam int SPEED_W    = 16;
  localparam int NUM_W      = 24;
  localparam int STALL_W    = 14;
  localparam int SLEW_W     = 8;
  localparam int RAW_W      = 8;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_NUM  = 2'd0,
    CFG_STALL      = 2'd1,
    CFG_SLEW_FLOOR = 2'd2,
    CFG_SLEW_CEIL  = 2'd3
  } hcs_cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [NUM_W-1:0]   SPEED_NUM_RST  = 24'd2500000;
  localparam logic [STALL_W-1:0] STALL_RST      = 14'd5000;
  localparam logic [SLEW_W-1:0]  SLEW_FLOOR_RST = 8'd20;
  localparam logic [SLEW_W-1:0]  SLEW_CEIL_RST  = 8'd200;
  localparam logic [SLEW_W-1:0]  SLEW_LIM_RST   = 8'd20;

  // Idle counter saturation point
  localparam logic [STALL_W-1:0] IDLE_SAT = 14'd11000;

  // Start-mode tick count after which start_done fires
  localparam logic [2:0] START_TICKS_MAX = 3'd3;

  // Speed saturation value
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

  // Hall code (A*4 + C*2 + B) to raw sector; 0x7F and 0xFF mark invalid codes
  localparam logic [RAW_W-1:0] SECTOR_TABLE [8] = '{
    8'h7F, 8'd6, 8'd2, 8'd1, 8'd4, 8'd5, 8'd3, 8'hFF
  };
  localparam logic [RAW_W-1:0] RAW_INVALID_HI = 8'hFF;
  localparam logic [RAW_W-1:0] SECTOR_LAST    = 8'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_SLEW,
    ST_DONE
  } hcs_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } hcs_div_stat_t;

endpackage

// File: src/hcs_hall_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_hall_decode
// Hall code to raw sector lookup, reported sector and commutation step.
// ----------------------------------------------------------------------------
module hcs_hall_decode (
  input  logic                     hall_a,
  input  logic                     hall_b,
  input  logic                     hall_c,
  input  logic                     drive_reverse,
  output logic [hcs_pkg::RAW_W-1:0] raw,
  output logic [2:0]               sector,
  output logic [2:0]               step
);
  import hcs_pkg::*;

  logic [2:0] code;

  assign code = {hall_a, hall_c, hall_b};
  assign raw  = SECTOR_TABLE[code];

  // invalid codes report sector 0
  assign sector = (raw <= SECTOR_LAST) ? raw[2:0] : 3'd0;

  // forward: next sector, wrapping 6 to 1; code 7 wraps through zero to 6
  // reverse: two sectors back, wrapping in 1..6
  always_comb begin
    step = 3'd1;
    if (!drive_reverse) begin
      case (raw) inside
        [8'd1:8'd5]:    step = raw[2:0] + 3'd1;
        RAW_INVALID_HI: step = 3'd6;
        default:        step = 3'd1;
      endcase
    end else begin
      case (raw) inside
        8'd1:        step = 3'd5;
        8'd2:        step = 3'd6;
        [8'd3:8'd6]: step = raw[2:0] - 3'd2;
        default:     step = 3'd1;
      endcase
    end
  end

endmodule

// File: src/hcs_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_serial_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hcs_serial_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      numerator,
  input  logic [DEN_W-1:0]      divisor,
  output hcs_pkg::hcs_div_stat_t stat,
  output logic [NUM_W-1:0]      quotient
);
  import hcs_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] shreg_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  assign trial = {rem_r, shreg_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg_r <= numerator;
      rem_r   <= '0;
      den_r   <= divisor;
    end else if (busy_r) begin
      shreg_r <= {shreg_r[NUM_W-2:0], ge};
      rem_r   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = shreg_r;

endmodule

// File: src/hall_commutation_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_commutation_speed
// Hall sensor commutation and speed measurement, one result beat per tick.
// ----------------------------------------------------------------------------
// Each input beat is one sensor tick: three Hall levels, drive direction,
// start-mode flag and a free-running timer sample. Each tick returns one
// result beat with the commutation step, decoded sector, slew-limited speed
// (plain and signed), rotation sign and a start_done pulse. Items are handled
// one at a time: a tick that does not close a measurement passes through
// the evaluate and output states before the next tick is accepted; every
// CHANGES_PER_MEASURE-th sector change also runs the speed division through
// a radix-2 serial divider, one quotient bit per cycle over the 24-bit
// numerator. The input is stalled for the whole time a tick is being worked
// on. The result sits in an output register, so the next beat is accepted
// while it waits; a finished result that finds the previous one still not
// taken holds in the last state. A zero timer delta divides to all ones and
// so saturates at 65535. Configuration writes are taken at any time but must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module hall_commutation_speed #(
  parameter int CHANGES_PER_MEASURE = 5,
  parameter int TIMER_BITS          = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_hall_a,
  input  logic                           in_hall_b,
  input  logic                           in_hall_c,
  input  logic                           in_drive_reverse,
  input  logic                           in_start_mode,
  input  logic [hcs_pkg::TIMER_IN_W-1:0] in_timer_count,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_commutation_step,
  output logic [2:0]                     out_hall_sector,
  output logic [hcs_pkg::SPEED_W-1:0]    out_speed_magnitude,
  output logic signed [hcs_pkg::SPEED_W-1:0] out_speed_signed,
  output logic                           out_rotating_negative,
  output logic                           out_start_done,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [hcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcs_pkg::NUM_W-1:0]      cfg_wdata
);
  import hcs_pkg::*;

  localparam int CCW   = $clog2(CHANGES_PER_MEASURE + 1);
  localparam int TW_IN = (TIMER_BITS < TIMER_IN_W) ? TIMER_BITS : TIMER_IN_W;

  // configuration registers
  logic [NUM_W-1:0]   speed_num_r;
  logic [STALL_W-1:0] stall_ticks_r;
  logic [SLEW_W-1:0]  slew_floor_r;
  logic [SLEW_W-1:0]  slew_ceil_r;

  // control state
  hcs_state_t          state_r, state_nxt;
  logic [RAW_W-1:0]    last_sector_r, last_sector_nxt;
  logic [STALL_W-1:0]  idle_ticks_r, idle_ticks_nxt;
  logic [CCW-1:0]      change_count_r, change_count_nxt;
  logic [TIMER_BITS-1:0] last_timer_r, last_timer_nxt;
  logic [SPEED_W-1:0]  speed_now_r, speed_now_nxt;
  logic [SPEED_W-1:0]  speed_before_r, speed_before_nxt;
  logic [SLEW_W-1:0]   slew_limit_r, slew_limit_nxt;
  logic                sign_neg_r, sign_neg_nxt;
  logic [2:0]          start_ticks_r, start_ticks_nxt;
  logic                out_valid_r, out_valid_nxt;

  // captured beat and per-tick results
  logic                  hall_a_r, hall_b_r, hall_c_r;
  logic                  reverse_r, start_mode_r;
  logic [TIMER_IN_W-1:0] timer_r;
  logic [2:0]            step_r;
  logic [2:0]            sector_r;
  logic                  done_flag_r, done_flag_nxt;

  // output registers
  logic [2:0]         out_step_r;
  logic [2:0]         out_sector_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [SPEED_W-1:0] out_signed_r;
  logic               out_neg_r;
  logic               out_done_r;

  // strobes
  logic accept;
  logic eval_en;
  logic out_ld;
  logic div_start;

  // datapath
  logic [RAW_W-1:0]      raw;
  logic [2:0]            dec_sector;
  logic [2:0]            dec_step;
  logic [TIMER_BITS-1:0] timer_v;
  logic [TIMER_BITS-1:0] delta;
  hcs_div_stat_t         div_stat;
  logic [NUM_W-1:0]      div_quotient;
  logic [SPEED_W-1:0]    target;
  logic [SPEED_W-1:0]    diff;
  logic                  up;
  logic [SLEW_W:0]       lim_dbl;
  logic [SLEW_W-1:0]     lim_half;
  logic [SPEED_W-1:0]    speed_dec;
  logic [2:0]            st_inc;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  hcs_hall_decode u_decode (
    .hall_a        (hall_a_r),
    .hall_b        (hall_b_r),
    .hall_c        (hall_c_r),
    .drive_reverse (reverse_r),
    .raw           (raw),
    .sector        (dec_sector),
    .step          (dec_step)
  );

  // timer sample held to TIMER_BITS, delta wraps at the same width
  assign timer_v = TIMER_BITS'(timer_r[TW_IN-1:0]);
  assign delta   = timer_v - last_timer_r;

  hcs_serial_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIMER_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .numerator (speed_num_r),
    .divisor   (delta),
    .stat      (div_stat),
    .quotient  (div_quotient)
  );

  // slew limiter inputs
  assign target   = (|div_quotient[NUM_W-1:SPEED_W]) ? SPEED_MAX
                                                     : div_quotient[SPEED_W-1:0];
  assign up       = target > speed_before_r;
  assign diff     = up ? (target - speed_before_r) : (speed_before_r - target);
  assign lim_dbl  = {slew_limit_r, 1'b0};
  assign lim_half = slew_limit_r >> 1;

  // idle decay, applied on the way out
  assign speed_dec = ((idle_ticks_r > stall_ticks_r) && (speed_now_r != '0)) ?
                     (speed_now_r - SPEED_W'(1)) : speed_now_r;

  assign st_inc = start_ticks_r + 3'd1;

  always_comb begin
    state_nxt        = state_r;
    last_sector_nxt  = last_sector_r;
    idle_ticks_nxt   = idle_ticks_r;
    change_count_nxt = change_count_r;
    last_timer_nxt   = last_timer_r;
    speed_now_nxt    = speed_now_r;
    speed_before_nxt = speed_before_r;
    slew_limit_nxt   = slew_limit_r;
    sign_neg_nxt     = sign_neg_r;
    start_ticks_nxt  = start_ticks_r;
    done_flag_nxt    = done_flag_r;
    eval_en          = 1'b0;
    out_ld           = 1'b0;
    div_start        = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        eval_en       = 1'b1;
        done_flag_nxt = 1'b0;
        if (start_mode_r) begin
          if (st_inc > START_TICKS_MAX) begin
            done_flag_nxt   = 1'b1;
            start_ticks_nxt = '0;
          end else begin
            start_ticks_nxt = st_inc;
          end
        end

        if (raw == last_sector_r) begin
          if (idle_ticks_r < IDLE_SAT) begin
            idle_ticks_nxt = idle_ticks_r + STALL_W'(1);
          end
        end else begin
          idle_ticks_nxt   = '0;
          change_count_nxt = change_count_r + CCW'(1);
          // sign only updates on a 3 <-> 4 transition
          if ((raw inside {[8'd3:8'd4]}) && (last_sector_r inside {[8'd3:8'd4]})) begin
            sign_neg_nxt = raw > last_sector_r;
          end
        end
        last_sector_nxt = raw;

        if (change_count_nxt >= CCW'(CHANGES_PER_MEASURE)) begin
          change_count_nxt = '0;
          last_timer_nxt   = timer_v;
          div_start        = 1'b1;
          state_nxt        = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_SLEW;
        end
      end

      ST_SLEW: begin
        if (diff > SPEED_W'(slew_limit_r)) begin
          speed_now_nxt = up ? (speed_before_r + SPEED_W'(slew_limit_r))
                             : (speed_before_r - SPEED_W'(slew_limit_r));
          if (slew_limit_r < slew_ceil_r) begin
            slew_limit_nxt = (lim_dbl > {1'b0, slew_ceil_r}) ? slew_ceil_r
                                                              : lim_dbl[SLEW_W-1:0];
          end
        end else begin
          speed_now_nxt = target;
          if (slew_limit_r > slew_floor_r) begin
            slew_limit_nxt = (lim_half < slew_floor_r) ? slew_floor_r : lim_half;
          end
        end
        speed_before_nxt = speed_now_nxt;
        state_nxt        = ST_DONE;
      end

      ST_DONE: begin
        done_flag_nxt = done_flag_r;
        if (!out_valid_r || !out_stall) begin
          speed_now_nxt = speed_dec;
          out_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      last_sector_r  <= '0;
      idle_ticks_r   <= '0;
      change_count_r <= '0;
      last_timer_r   <= '0;
      speed_now_r    <= '0;
      speed_before_r <= '0;
      slew_limit_r   <= SLEW_LIM_RST;
      sign_neg_r     <= 1'b0;
      start_ticks_r  <= '0;
      out_valid_r    <= 1'b0;
      done_flag_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      last_sector_r  <= last_sector_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
      change_count_r <= change_count_nxt;
      last_timer_r   <= last_timer_nxt;
      speed_now_r    <= speed_now_nxt;
      speed_before_r <= speed_before_nxt;
      slew_limit_r   <= slew_limit_nxt;
      sign_neg_r     <= sign_neg_nxt;
      start_ticks_r  <= start_ticks_nxt;
      out_valid_r    <= out_valid_nxt;
      done_flag_r    <= done_flag_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_num_r   <= SPEED_NUM_RST;
      stall_ticks_r <= STALL_RST;
      slew_floor_r  <= SLEW_FLOOR_RST;
      slew_ceil_r   <= SLEW_CEIL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_NUM:  speed_num_r   <= cfg_wdata;
        CFG_STALL:      stall_ticks_r <= cfg_wdata[STALL_W-1:0];
        CFG_SLEW_FLOOR: slew_floor_r  <= cfg_wdata[SLEW_W-1:0];
        CFG_SLEW_CEIL:  slew_ceil_r   <= cfg_wdata[SLEW_W-1:0];
        default: ;
      endcase
    end
  end

  // beat capture, tick results and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hall_a_r     <= in_hall_a;
      hall_b_r     <= in_hall_b;
      hall_c_r     <= in_hall_c;
      reverse_r    <= in_drive_reverse;
      start_mode_r <= in_start_mode;
      timer_r      <= in_timer_count;
    end
    if (eval_en) begin
      step_r   <= dec_step;
      sector_r <= dec_sector;
    end
    if (out_ld) begin
      out_step_r   <= step_r;
      out_sector_r <= sector_r;
      out_speed_r  <= speed_dec;
      out_signed_r <= sign_neg_r ? (SPEED_W'(0) - speed_dec) : speed_dec;
      out_neg_r    <= sign_neg_r;
      out_done_r   <= done_flag_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_commutation_step  = out_step_r;
  assign out_hall_sector       = out_sector_r;
  assign out_speed_magnitude   = out_speed_r;
  assign out_speed_signed      = out_signed_r;
  assign out_rotating_negative = out_neg_r;
  assign out_start_done        = out_done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_sat: assert property (@(posedge clk) disable iff (!rst_n)
    idle_ticks_r <= IDLE_SAT)
    else $error("idle tick count beyond saturation");

  a_start_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    start_ticks_r <= START_TICKS_MAX)
    else $error("start tick count out of range");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == ST_DIV))
    else $error("divider active outside division state");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=>
      (state_r == ST_DONE && out_valid_r))
    else $error("result overwrote a beat still waiting");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hall commutation and speed block.
// ----------------------------------------------------------------------------
// A directed table exercises the invalid Hall codes, every sector in both
// drive directions, rotation-sign flips, start-mode completion, a zero timer
// delta and both ends of the timer range. Random phases follow under several
// register settings. They mostly spin the rotor through well-formed sector
// sequences with random holds, timer steps and start bursts, mixed with noise
// beats and glitched codes. Every result beat is checked field by field
// against typed table values or an in-bench commutation and speed model.
// ----------------------------------------------------------------------------
module testbench;
  import hcs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MEASURE_EVERY = 5;
  localparam int IDLE_CAP = 11000;

  // One expected result beat
  typedef struct packed {
    logic [2:0]  step;
    logic [2:0]  sector;
    logic [15:0] speed;
    logic [15:0] sspeed;
    logic        neg;
    logic        done;
  } tick_result_t;

  // Directed row; hall bits are {a, b, c}. Typed rows carry step/sector/speed,
  // with signed speed equal to speed, and sign and start_done implied zero.
  typedef struct packed {
    logic [2:0]  abc;
    logic        rev;
    logic        start;
    logic [15:0] timer;
    logic        typed;
    logic [2:0]  x_step;
    logic [2:0]  x_sector;
    logic [15:0] x_speed;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // invalid codes straight after reset: 0 and 7 forward, 7 and 0 reverse
    '{3'b000, 1'b0, 1'b0, 16'd0,     1'b1, 3'd1, 3'd0, 16'd0},
    '{3'b111, 1'b0, 1'b0, 16'd0,     1'b1, 3'd6, 3'd0, 16'd0},
    '{3'b111, 1'b1, 1'b0, 16'd0,     1'b1, 3'd1, 3'd0, 16'd0},
    '{3'b000, 1'b1, 1'b0, 16'd0,     1'b1, 3'd1, 3'd0, 16'd0},
    // 3 -> 4 goes negative and closes the first measurement; start ticks run
    '{3'b101, 1'b0, 1'b1, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b100, 1'b0, 1'b1, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b101, 1'b1, 1'b1, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b001, 1'b1, 1'b1, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b011, 1'b1, 1'b0, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b010, 1'b1, 1'b0, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    // same timer as last measurement: zero delta saturates
    '{3'b110, 1'b1, 1'b0, 16'd100,   1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b100, 1'b0, 1'b0, 16'd65535, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b101, 1'b0, 1'b0, 16'd65535, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b100, 1'b0, 1'b0, 16'd65535, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b110, 1'b0, 1'b0, 16'd0,     1'b0, 3'd0, 3'd0, 16'd0},
    // timer wraps through zero before this measurement closes
    '{3'b010, 1'b0, 1'b0, 16'd0,     1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b011, 1'b0, 1'b1, 16'd40000, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b001, 1'b0, 1'b1, 16'd40020, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b001, 1'b0, 1'b1, 16'd40020, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b101, 1'b0, 1'b1, 16'd40030, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b100, 1'b1, 1'b0, 16'd40100, 1'b0, 3'd0, 3'd0, 16'd0},
    // full-range delta: smallest nonzero quotient
    '{3'b110, 1'b1, 1'b0, 16'd65535, 1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b010, 1'b0, 1'b0, 16'd0,     1'b0, 3'd0, 3'd0, 16'd0},
    '{3'b011, 1'b1, 1'b0, 16'd65535, 1'b0, 3'd0, 3'd0, 16'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_hall_a, in_hall_b, in_hall_c;
  logic        in_drive_reverse;
  logic        in_start_mode;
  logic [15:0] in_timer_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_commutation_step;
  logic [2:0]  out_hall_sector;
  logic [15:0] out_speed_magnitude;
  logic signed [15:0] out_speed_signed;
  logic        out_rotating_negative;
  logic        out_start_done;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NUM_W-1:0]     cfg_wdata;

  hall_commutation_speed dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_hall_a            (in_hall_a),
    .in_hall_b            (in_hall_b),
    .in_hall_c            (in_hall_c),
    .in_drive_reverse     (in_drive_reverse),
    .in_start_mode        (in_start_mode),
    .in_timer_count       (in_timer_count),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_commutation_step (out_commutation_step),
    .out_hall_sector      (out_hall_sector),
    .out_speed_magnitude  (out_speed_magnitude),
    .out_speed_signed     (out_speed_signed),
    .out_rotating_negative(out_rotating_negative),
    .out_start_done       (out_start_done),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Commutation/speed model: register copies and tracked state
  // --------------------------------------------------------------------------
  int unsigned cfg_num   = 2500000;
  int unsigned cfg_stall = 5000;
  int unsigned cfg_floor = 20;
  int unsigned cfg_ceil  = 200;

  logic [7:0]  last_raw   = 8'd0;
  int unsigned idle_cnt   = 0;
  int unsigned change_cnt = 0;
  logic [15:0] last_time  = 16'd0;
  int unsigned spd_now    = 0;
  int unsigned spd_prev   = 0;
  int unsigned slew_lim   = 20;
  logic        neg_rot    = 1'b0;
  logic [2:0]  boot_ticks = 3'd0;

  tick_result_t expected_q[$];
  int          error_count = 0;
  int          beat_count  = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;       // no idling on either side while set

  // random sequence state
  int          rotor_pos = 1;
  logic [15:0] timer_now = 16'd0;

  // Advance the model by one tick and return the beat it must produce
  function automatic tick_result_t predict_tick(input logic [2:0] abc, input logic rev,
                                                input logic start,
                                                input logic [15:0] tmr);
    tick_result_t r;
    logic [7:0]   raw;
    logic [7:0]   s;
    logic [15:0]  delta;
    int unsigned  target, diff, q, grown, shrunk;
    r = '0;
    // code weights: A 4, C 2, B 1
    case ({abc[2], abc[0], abc[1]})
      3'd0:    raw = 8'h7F;
      3'd1:    raw = 8'd6;
      3'd2:    raw = 8'd2;
      3'd3:    raw = 8'd1;
      3'd4:    raw = 8'd4;
      3'd5:    raw = 8'd5;
      3'd6:    raw = 8'd3;
      default: raw = 8'hFF;
    endcase

    // 8-bit step arithmetic; invalid codes fold through the final clamp
    if (!rev) begin
      s = raw + 8'd1;
    end else begin
      s = raw - 8'd1;
      if (s < 8'd1) s = 8'd6;
      s = s - 8'd1;
      if (s < 8'd1) s = 8'd6;
    end
    if (s > 8'd6) s = 8'd1;
    else if (s < 8'd1) s = 8'd6;

    if (start) begin
      boot_ticks = boot_ticks + 3'd1;
      if (boot_ticks > 3'd3) begin
        r.done = 1'b1;
        boot_ticks = 3'd0;
      end
    end

    if (raw == last_raw) begin
      if (idle_cnt < IDLE_CAP) idle_cnt++;
    end else begin
      idle_cnt = 0;
      change_cnt++;
      // sign only moves on a 3 <-> 4 transition
      if (raw >= 8'd3 && raw <= 8'd4 && last_raw >= 8'd3 && last_raw <= 8'd4)
        neg_rot = (raw > last_raw);
    end

    if (change_cnt >= MEASURE_EVERY) begin
      delta = tmr - last_time;
      change_cnt = 0;
      last_time = tmr;
      if (delta == 16'd0) begin
        target = 65535;
      end else begin
        q = cfg_num / delta;
        target = (q > 65535) ? 65535 : q;
      end
      diff = (target > spd_prev) ? target - spd_prev : spd_prev - target;
      if (diff > slew_lim) begin
        target = (target > spd_prev) ? spd_prev + slew_lim : spd_prev - slew_lim;
        if (slew_lim < cfg_ceil) begin
          grown = slew_lim << 1;
          slew_lim = (grown > cfg_ceil) ? cfg_ceil : grown;
        end
      end else if (slew_lim > cfg_floor) begin
        shrunk = slew_lim >> 1;
        slew_lim = (shrunk < cfg_floor) ? cfg_floor : shrunk;
      end
      spd_now = target & 32'hFFFF;
      spd_prev = spd_now;
    end

    // stall decay touches only the reported speed
    if (idle_cnt > cfg_stall && spd_now > 0) spd_now--;
    last_raw = raw;

    r.step   = s[2:0];
    r.sector = (raw <= 8'd6) ? raw[2:0] : 3'd0;
    r.speed  = spd_now[15:0];
    r.sspeed = neg_rot ? (16'd0 - spd_now[15:0]) : spd_now[15:0];
    r.neg    = neg_rot;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] beat %0d: %s", $time, beat_count, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: present one tick beat, hold it until taken
  // --------------------------------------------------------------------------
  task automatic push_tick(input logic [2:0] abc, input logic rev, input logic start,
                           input logic [15:0] tmr, input logic typed,
                           input tick_result_t typed_res);
    tick_result_t r;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_hall_a        <= abc[2];
    in_hall_b        <= abc[1];
    in_hall_c        <= abc[0];
    in_drive_reverse <= rev;
    in_start_mode    <= start;
    in_timer_count   <= tmr;
    in_valid         <= 1'b1;
    // values read right after the edge are the ones the edge saw
    do @(posedge clk); while (in_stall);
    r = predict_tick(abc, rev, start, tmr);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  // Registers change only with nothing in flight
  task automatic apply_settings(input int unsigned num, input int unsigned stall,
                                input int unsigned floor_v, input int unsigned ceil_v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_SPEED_NUM;  cfg_wdata <= NUM_W'(num);
    @(negedge clk);
    cfg_index <= CFG_STALL;      cfg_wdata <= NUM_W'(stall);
    @(negedge clk);
    cfg_index <= CFG_SLEW_FLOOR; cfg_wdata <= NUM_W'(floor_v);
    @(negedge clk);
    cfg_index <= CFG_SLEW_CEIL;  cfg_wdata <= NUM_W'(ceil_v);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_num = num; cfg_stall = stall; cfg_floor = floor_v; cfg_ceil = ceil_v;
  endtask

  // Mostly well-formed rotation bursts; some noise bursts and glitched codes
  task automatic run_random(input int count);
    int          n, burst_left, hold_left, start_left, tmin, tmax;
    bit          noisy, dir_rev;
    logic [2:0]  abc;
    logic        rev, st;
    logic [15:0] tmr;
    burst_left = 0; hold_left = 0; start_left = 0;
    noisy = 1'b0; dir_rev = 1'b0; tmin = 0; tmax = 10;
    for (n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 4);
        noisy = ($urandom_range(7) == 0);
        dir_rev = $urandom_range(1);
        case ($urandom_range(3))
          0:       begin tmin = 0;    tmax = 10;    end  // saturating speeds
          1:       begin tmin = 5;    tmax = 200;   end
          2:       begin tmin = 200;  tmax = 3000;  end
          default: begin tmin = 3000; tmax = 20000; end
        endcase
      end
      burst_left--;
      if (start_left > 0) start_left--;
      else if ($urandom_range(15) == 0) start_left = $urandom_range(8, 1);
      st = (start_left > 0);
      if (noisy) begin
        abc = $urandom_range(7);
        rev = $urandom_range(1);
        st  = $urandom_range(1);
        tmr = $urandom_range(65535);
      end else begin
        if (hold_left > 0) begin
          hold_left--;
        end else if ($urandom_range(9) == 0) begin
          hold_left = $urandom_range(12, 1);
        end else if (dir_rev) begin
          rotor_pos = (rotor_pos == 1) ? 6 : rotor_pos - 1;
        end else begin
          rotor_pos = (rotor_pos == 6) ? 1 : rotor_pos + 1;
        end
        case (rotor_pos)
          1:       abc = 3'b011;
          2:       abc = 3'b001;
          3:       abc = 3'b101;
          4:       abc = 3'b100;
          5:       abc = 3'b110;
          default: abc = 3'b010;
        endcase
        // occasional sensor glitch to an invalid code
        if ($urandom_range(39) == 0) abc = $urandom_range(1) ? 3'b111 : 3'b000;
        rev = ($urandom_range(19) == 0) ? !dir_rev : dir_rev;
        timer_now = timer_now + 16'($urandom_range(tmax, tmin));
        tmr = timer_now;
      end
      push_tick(abc, rev, st, tmr, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, checker against the oldest expectation
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (out_commutation_step !== want.step)
          report_mismatch($sformatf("commutation_step %0d, want %0d",
                                    out_commutation_step, want.step));
        if (out_hall_sector !== want.sector)
          report_mismatch($sformatf("hall_sector %0d, want %0d",
                                    out_hall_sector, want.sector));
        if (out_speed_magnitude !== want.speed)
          report_mismatch($sformatf("speed_magnitude %0d, want %0d",
                                    out_speed_magnitude, want.speed));
        if (out_speed_signed !== want.sspeed)
          report_mismatch($sformatf("speed_signed %0d, want %0d",
                                    out_speed_signed, $signed(want.sspeed)));
        if (out_rotating_negative !== want.neg)
          report_mismatch($sformatf("rotating_negative %0b, want %0b",
                                    out_rotating_negative, want.neg));
        if (out_start_done !== want.done)
          report_mismatch($sformatf("start_done %0b, want %0b",
                                    out_start_done, want.done));
      end
      beat_count++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hall_commutation_speed verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int           i;
    tick_result_t typed_res;
    int unsigned  fl;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_hall_a = 1'b0; in_hall_b = 1'b0; in_hall_c = 1'b0;
    in_drive_reverse = 1'b0;
    in_start_mode = 1'b0;
    in_timer_count = 16'd0;
    cfg_we = 1'b0;
    cfg_index = CFG_SPEED_NUM;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at reset settings
    for (i = 0; i < DIR_ROWS; i++) begin
      typed_res = '0;
      typed_res.step   = DIRECTED[i].x_step;
      typed_res.sector = DIRECTED[i].x_sector;
      typed_res.speed  = DIRECTED[i].x_speed;
      typed_res.sspeed = DIRECTED[i].x_speed;
      push_tick(DIRECTED[i].abc, DIRECTED[i].rev, DIRECTED[i].start,
                DIRECTED[i].timer, DIRECTED[i].typed, typed_res);
    end
    run_random(80);

    // top extremes; stall of one makes decay show up on short holds;
    // both sides run without gaps for this whole phase
    apply_settings(16777215, 1, 1, 255);
    quiet = 1'b1;
    run_random(90);
    quiet = 1'b0;

    // bottom extremes: floor above ceiling pins the slew limit
    apply_settings(1, 11000, 255, 1);
    run_random(60);

    fl = $urandom_range(60, 1);
    apply_settings($urandom_range(5000000, 100000), $urandom_range(40, 1), fl,
                   $urandom_range(255, fl));
    run_random(100);

    apply_settings(2500000, 5000, 20, 200);
    run_random(80);

    fl = $urandom_range(255, 1);
    apply_settings($urandom_range(16777215, 1), $urandom_range(11000, 1), fl,
                   $urandom_range(255, 1));
    run_random(50);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", expected_q.size()));
    if (error_count == 0) begin
      $display("hall_commutation_speed verification clean");
    end else begin
      $display("hall_commutation_speed verification failed");
    end
    $finish;
  end

endmodule
